// ===== rtl/h264_nal_fu_a_packetizer_core_defines.svh =====
// ---------------------------------------------------------------------------
// H.264 FU-A packetizer assertion macros
// Clocked assertion helpers used by the packetizer core. In synthesis the
// macros expand to nothing.
// ---------------------------------------------------------------------------
`ifndef H264_NAL_FU_A_PACKETIZER_CORE_DEFINES_SVH
`define H264_NAL_FU_A_PACKETIZER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked at every rising edge of clk, ignored while rst is high.
`define H264FU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication from a condition to a property that must hold in the next cycle.
`define H264FU_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`else

`define H264FU_ASSERT(lbl, prop, msg)
`define H264FU_ASSERT_NEXT(lbl, cond, prop, msg)

`endif

`endif

// ===== rtl/h264fu_pkg.sv =====
// ---------------------------------------------------------------------------
// H.264 FU-A packetizer package
// Item types, register indexes and protocol constants of the packetizer.
// ---------------------------------------------------------------------------
package h264fu_pkg;

  // Largest supported NAL unit length in bytes.
  localparam int unsigned MAX_UNIT_BYTES_DEF = 524288;

  // Width of the position, length and limit comparisons.
  localparam int unsigned CMP_W = 22;

  // RFC 6184 constants.
  localparam logic [7:0] NRI_MASK     = 8'h60;
  localparam logic [7:0] TYPE_MASK    = 8'h1F;
  localparam logic [7:0] FU_A_TYPE    = 8'd28;
  localparam logic [7:0] FU_START_BIT = 8'h80;
  localparam logic [7:0] FU_END_BIT   = 8'h40;

  // Register limits and reset values.
  localparam logic [10:0] MIN_PAYLOAD        = 11'd16;
  localparam logic [10:0] MAX_PAYLOAD_RST    = 11'd1400;
  localparam logic [15:0] TIMESTAMP_STEP_RST = 16'(90000 / 25);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_MAX_PAYLOAD    = 1'b0,
    REG_TIMESTAMP_STEP = 1'b1
  } cfg_reg_t;

  // One NAL byte with the length of its unit.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [19:0] unit_length;
  } in_item_t;

  // One RTP payload byte with its packet marks.
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        packet_first;
    logic        packet_last;
    logic [15:0] seq_number;
    logic [31:0] time_stamp;
    logic        run_end;
  } out_item_t;

  // Unit state other than the byte position.
  typedef struct packed {
    logic [7:0]  unit_header;
    logic [10:0] fragment_fill;
    logic        fragmenting;
    logic [15:0] seq_counter;
    logic [31:0] stamp_counter;
  } unit_state_t;

  // One payload byte slot of a result group.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       packet_first;
    logic       packet_last;
  } res_slot_t;

  // All results caused by one input byte, last one in slot count-1.
  typedef struct packed {
    res_slot_t [2:0] slot;
    logic [1:0]      count;
    logic [15:0]     seq_number;
    logic [31:0]     time_stamp;
  } res_group_t;

endpackage

// ===== rtl/h264fu_stream_if.sv =====
// ---------------------------------------------------------------------------
// H.264 FU-A packetizer stream interface
// Valid/ready channel carrying one word of the given payload type.
// ---------------------------------------------------------------------------
interface h264fu_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/h264fu_step.sv =====
// ---------------------------------------------------------------------------
// H.264 FU-A packetizer step logic
// Works out the result group and the next unit state for one NAL byte.
// ---------------------------------------------------------------------------
module h264fu_step #(
  parameter int unsigned MAX_UNIT_BYTES = h264fu_pkg::MAX_UNIT_BYTES_DEF,
  parameter int unsigned POS_W          = $clog2(MAX_UNIT_BYTES)
) (
  input  h264fu_pkg::in_item_t    item,
  input  logic [POS_W-1:0]        pos,
  input  h264fu_pkg::unit_state_t st,
  input  logic [10:0]             max_payload,
  input  logic [15:0]             timestamp_step,
  output logic [POS_W-1:0]        pos_next,
  output h264fu_pkg::unit_state_t st_next,
  output h264fu_pkg::res_group_t  group
);

  localparam int unsigned CW = h264fu_pkg::CMP_W;
  localparam logic [CW-1:0] MAX_LEN = CW'(MAX_UNIT_BYTES);

  logic [10:0]   lim;
  logic [CW-1:0] len;
  logic [CW-1:0] pos_x;
  logic [CW-1:0] lim_x;
  logic [CW-1:0] fill_x;
  logic          head;
  logic          frag;
  logic [7:0]    hdr;
  logic [10:0]   fill;
  logic          endu;
  logic          close;
  logic [7:0]    fuh;

  // Clamp the payload limit and the unit length into their working ranges.
  always_comb begin
    lim = (max_payload < h264fu_pkg::MIN_PAYLOAD) ? h264fu_pkg::MIN_PAYLOAD : max_payload;
    len = CW'(item.unit_length);
    if (len == '0) begin
      len = CW'(1);
    end else if (len > MAX_LEN) begin
      len = MAX_LEN;
    end
  end

  assign pos_x  = CW'(pos);
  assign lim_x  = CW'(lim);
  assign head   = (pos == '0);
  assign frag   = head ? (len > lim_x) : st.fragmenting;
  assign hdr    = head ? item.data_byte : st.unit_header;
  assign fill   = head ? 11'd0 : st.fragment_fill;
  assign fill_x = CW'(fill);

  // Unit end, fragment close and FU header byte.
  always_comb begin
    if (frag) begin
      endu = (pos_x + CW'(1) >= len);
    end else begin
      endu = (pos_x + CW'(1) >= len) || (pos_x + CW'(1) >= lim_x);
    end
    close = endu || (fill_x + CW'(1) >= lim_x) ||
            ((pos_x == fill_x + CW'(1)) && (pos_x + CW'(2) == len));
    fuh = hdr & h264fu_pkg::TYPE_MASK;
    if (pos_x == CW'(1)) begin
      fuh = fuh | h264fu_pkg::FU_START_BIT;
    end else if (endu || (len <= pos_x + lim_x)) begin
      fuh = fuh | h264fu_pkg::FU_END_BIT;
    end
  end

  // Result group and next state.
  always_comb begin
    st_next                     = st;
    st_next.unit_header         = hdr;
    st_next.fragmenting         = frag;
    st_next.fragment_fill       = fill;
    pos_next                    = pos + POS_W'(1);
    group.seq_number            = st.seq_counter;
    group.time_stamp            = st.stamp_counter;
    group.count                 = 2'd0;
    group.slot                  = '0;
    if (!frag) begin
      // Single NAL unit packet: the byte passes through.
      group.count               = 2'd1;
      group.slot[0].payload_byte = item.data_byte;
      group.slot[0].packet_first = head;
      group.slot[0].packet_last  = endu;
      if (endu) begin
        st_next.seq_counter   = st.seq_counter + 16'd1;
        st_next.stamp_counter = st.stamp_counter + 32'(timestamp_step);
        pos_next              = '0;
      end
    end else if (!head) begin
      // FU-A data byte, behind an indicator and FU header when a fragment opens.
      if (fill == 11'd0) begin
        group.count                = 2'd3;
        group.slot[0].payload_byte = (hdr & h264fu_pkg::NRI_MASK) | h264fu_pkg::FU_A_TYPE;
        group.slot[0].packet_first = 1'b1;
        group.slot[1].payload_byte = fuh;
        group.slot[2].payload_byte = item.data_byte;
        group.slot[2].packet_last  = close;
      end else begin
        group.count                = 2'd1;
        group.slot[0].payload_byte = item.data_byte;
        group.slot[0].packet_last  = close;
      end
      if (close) begin
        st_next.fragment_fill = 11'd0;
        st_next.seq_counter   = st.seq_counter + 16'd1;
      end else begin
        st_next.fragment_fill = fill + 11'd1;
      end
      if (endu) begin
        st_next.stamp_counter = st.stamp_counter + 32'(timestamp_step);
        st_next.fragment_fill = 11'd0;
        pos_next              = '0;
      end
    end
  end

endmodule

// ===== rtl/h264_nal_fu_a_packetizer_core.sv =====
// ---------------------------------------------------------------------------
// H.264 NAL unit to RTP FU-A packetizer
// Turns a NAL byte stream into RTP payload bytes, as single NAL unit
// packets or FU-A fragments, with sequence numbers and timestamps.
// ---------------------------------------------------------------------------
//
//   Channel     Role   Word
//   nal_bytes   sink   in_item_t:  NAL byte and unit length
//   rtp_bytes   source out_item_t: payload byte, packet marks, seq, stamp
//   wr_*        sink   register write: index 0 max_payload, 1 timestamp_step
//
// A NAL byte waits in the input register and is worked out combinationally into
// a group of zero to three payload words held in the result register.
// Data bytes stream at one word per cycle while rtp_bytes is ready; a byte that
// opens an FU-A fragment gives three words and stalls the input until all go.
// With a result waiting, a new byte enters only an empty or emptying input register.
// Reset is synchronous; it empties both registers and clears the unit state.
//
module h264_nal_fu_a_packetizer_core #(
  parameter int unsigned MAX_UNIT_BYTES = h264fu_pkg::MAX_UNIT_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  h264fu_stream_if.sink                nal_bytes,
  h264fu_stream_if.source              rtp_bytes,
  input  logic                         wr_en,
  input  h264fu_pkg::cfg_reg_t         wr_index,
  input  logic [15:0]                  wr_data
);

`include "h264_nal_fu_a_packetizer_core_defines.svh"

  localparam int unsigned POS_W = $clog2(MAX_UNIT_BYTES);

  logic [10:0]             max_payload;
  logic [15:0]             timestamp_step;
  logic                    in_full;
  h264fu_pkg::in_item_t    in_item;
  logic [POS_W-1:0]        byte_position;
  h264fu_pkg::unit_state_t unit_state;
  logic [POS_W-1:0]        pos_next;
  h264fu_pkg::unit_state_t state_next;
  h264fu_pkg::res_group_t  group_next;
  h264fu_pkg::res_group_t  group;
  logic                    group_valid;
  logic [1:0]              slot_idx;
  logic                    slot_last;
  logic                    out_take;
  logic                    advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload    <= h264fu_pkg::MAX_PAYLOAD_RST;
      timestamp_step <= h264fu_pkg::TIMESTAMP_STEP_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        h264fu_pkg::REG_MAX_PAYLOAD:    max_payload    <= wr_data[10:0];
        h264fu_pkg::REG_TIMESTAMP_STEP: timestamp_step <= wr_data;
        default: ;
      endcase
    end
  end

  // Per-byte logic.
  h264fu_step #(
    .MAX_UNIT_BYTES (MAX_UNIT_BYTES),
    .POS_W          (POS_W)
  ) u_step (
    .item           (in_item),
    .pos            (byte_position),
    .st             (unit_state),
    .max_payload    (max_payload),
    .timestamp_step (timestamp_step),
    .pos_next       (pos_next),
    .st_next        (state_next),
    .group          (group_next)
  );

  // Handshake control: the held byte moves on when its group has room.
  assign slot_last       = (slot_idx == group.count - 2'd1);
  assign out_take        = group_valid && rtp_bytes.ready;
  assign advance         = in_full &&
                           ((group_next.count == 2'd0) || !group_valid ||
                            (out_take && slot_last));
  assign nal_bytes.ready = !in_full || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (nal_bytes.valid && nal_bytes.ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (nal_bytes.valid && nal_bytes.ready) begin
      in_item <= nal_bytes.payload;
    end
  end

  // Unit state.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      unit_state    <= '0;
    end else if (advance) begin
      byte_position <= pos_next;
      unit_state    <= state_next;
    end
  end

  // Result register, emptied one word per handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_valid <= 1'b0;
      slot_idx    <= 2'd0;
    end else if (advance && (group_next.count != 2'd0)) begin
      group_valid <= 1'b1;
      slot_idx    <= 2'd0;
    end else if (out_take) begin
      if (slot_last) begin
        group_valid <= 1'b0;
      end else begin
        slot_idx <= slot_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (group_next.count != 2'd0)) begin
      group <= group_next;
    end
  end

  // Output word.
  assign rtp_bytes.valid                = group_valid;
  assign rtp_bytes.payload.payload_byte = group.slot[slot_idx].payload_byte;
  assign rtp_bytes.payload.packet_first = group.slot[slot_idx].packet_first;
  assign rtp_bytes.payload.packet_last  = group.slot[slot_idx].packet_last;
  assign rtp_bytes.payload.seq_number   = group.seq_number;
  assign rtp_bytes.payload.time_stamp   = group.time_stamp;
  assign rtp_bytes.payload.run_end      = slot_last;

  // A held group always has at least one word in range.
  `H264FU_ASSERT(a_group_count,
    !group_valid || ((group.count != 2'd0) && (slot_idx < group.count)),
    "result group empty or index out of range")

  // An open fragment only exists in a fragmented unit.
  `H264FU_ASSERT(a_fill_frag,
    (unit_state.fragment_fill == 11'd0) || unit_state.fragmenting,
    "fragment fill without fragmentation")

  // A packet start that is not the last word of its group is an FU indicator.
  `H264FU_ASSERT(a_fu_indicator,
    !(rtp_bytes.valid && rtp_bytes.payload.packet_first && !rtp_bytes.payload.run_end) ||
    (rtp_bytes.payload.payload_byte[4:0] == h264fu_pkg::FU_A_TYPE[4:0]),
    "packet start inside a group is not an FU indicator")

  // Sequence number only moves when a byte is processed.
  `H264FU_ASSERT_NEXT(a_seq_hold, !advance, $stable(unit_state.seq_counter),
    "sequence counter moved without a byte")

endmodule
